@@ design/alts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alts_pkg
// Shared widths, breakpoints and per-segment coefficients for the level to
// S-unit converter.
// ----------------------------------------------------------------------------
package alts_pkg;

    localparam int X_W     = 12;   // converter level
    localparam int CNT_W   = 4;    // breakpoints below the level, 0..10
    localparam int SEG_W   = 4;    // segment index, 0..8
    localparam int K_W     = 21;   // 100 * slope term, signed
    localparam int C_W     = 32;   // 100 * constant term, signed
    localparam int PROD_W  = K_W + X_W + 1;
    localparam int SUM_W   = C_W + 3;
    localparam int GAIN_W  = 31;   // 100 * gain numerator, always positive
    localparam int NUM_W   = 43;   // level * gain numerator
    localparam int DEN_W   = 32;   // r0 * r1 * (r1 - r0)
    localparam int Q_W     = 11;   // quotient, never above 1500
    localparam int NUM_BRK = 10;

    localparam logic [Q_W-1:0] FULL_SCALE = Q_W'(1500);

    localparam logic [X_W-1:0] BRK_LEVEL [NUM_BRK] = '{
        X_W'(27),   X_W'(215),  X_W'(640),  X_W'(1350), X_W'(2130),
        X_W'(2705), X_W'(3125), X_W'(3460), X_W'(3760), X_W'(4000)
    };

    // Result tag riding alongside the divider data.
    typedef struct packed {
        logic zero;   // level at or below the first breakpoint
        logic full;   // level above the last breakpoint
    } tag_t;

    // Per segment: value*100 = x * (c + k*x) / den, with c and k already
    // scaled by 100.
    typedef struct packed {
        logic signed [K_W-1:0] k;
        logic signed [C_W-1:0] c;
        logic [DEN_W-1:0]      den;
    } coef_t;

    function automatic coef_t seg_coef(input logic [SEG_W-1:0] seg);
        coef_t r;
        r = '0;
        case (seg)
            SEG_W'(0): begin
                r.k = K_W'(2700);     r.c = C_W'(-72900);
                r.den = DEN_W'(64'd1091340);
            end
            SEG_W'(1): begin
                r.k = K_W'(-21000);   r.c = C_W'(31715000);
                r.den = DEN_W'(64'd58480000);
            end
            SEG_W'(2): begin
                r.k = K_W'(-78000);   r.c = C_W'(241620000);
                r.den = DEN_W'(64'd613440000);
            end
            SEG_W'(3): begin
                r.k = K_W'(36000);    r.c = C_W'(449820000);
                r.den = DEN_W'(64'd2242890000);
            end
            SEG_W'(4): begin
                r.k = K_W'(138500);   r.c = C_W'(482682500);
                r.den = DEN_W'(64'd3312948750);
            end
            SEG_W'(5): begin
                r.k = K_W'(247000);   r.c = C_W'(250615000);
                r.den = DEN_W'(64'd3550312500);
            end
            SEG_W'(6): begin
                r.k = K_W'(11000);    r.c = C_W'(1008815000);
                r.den = DEN_W'(64'd3622187500);
            end
            SEG_W'(7): begin
                r.k = K_W'(392000);   r.c = C_W'(-228320000);
                r.den = DEN_W'(64'd3902880000);
            end
            SEG_W'(8): begin
                r.k = K_W'(840000);   r.c = C_W'(-2006400000);
                r.den = DEN_W'(64'd3609600000);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/alts_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alts_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit in Q_W bits (num < den << Q_W).
// ----------------------------------------------------------------------------
module alts_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [alts_pkg::NUM_W-1:0]  num,
    input  wire logic [alts_pkg::DEN_W-1:0]  den,
    input  wire alts_pkg::tag_t              in_tag,
    output logic                             out_valid,
    output logic [alts_pkg::Q_W-1:0]         quo,
    output alts_pkg::tag_t                   out_tag
);

    logic                        valid_reg [alts_pkg::Q_W];
    logic [alts_pkg::NUM_W-1:0]  rem_reg   [alts_pkg::Q_W];
    logic [alts_pkg::DEN_W-1:0]  den_reg   [alts_pkg::Q_W];
    logic [alts_pkg::Q_W-1:0]    quo_reg   [alts_pkg::Q_W];
    alts_pkg::tag_t              tag_reg   [alts_pkg::Q_W];

    genvar j;
    generate
        for (j = 0; j < alts_pkg::Q_W; j++) begin : g_stage
            localparam int BIT = alts_pkg::Q_W - 1 - j;

            logic                        v_in;
            logic [alts_pkg::NUM_W-1:0]  rem_in;
            logic [alts_pkg::DEN_W-1:0]  den_in;
            logic [alts_pkg::Q_W-1:0]    quo_in;
            alts_pkg::tag_t              tag_in;
            logic [alts_pkg::NUM_W-1:0]  trial;
            logic                        fits;
            logic [alts_pkg::Q_W-1:0]    quo_next;

            if (j == 0) begin : g_first
                always_comb
                begin
                    v_in   = in_valid;
                    rem_in = num;
                    den_in = den;
                    quo_in = '0;
                    tag_in = in_tag;
                end
            end else begin : g_next
                always_comb
                begin
                    v_in   = valid_reg[j-1];
                    rem_in = rem_reg[j-1];
                    den_in = den_reg[j-1];
                    quo_in = quo_reg[j-1];
                    tag_in = tag_reg[j-1];
                end
            end

            always_comb
            begin
                trial         = alts_pkg::NUM_W'(den_in) << BIT;
                fits          = (rem_in >= trial);
                quo_next      = quo_in;
                quo_next[BIT] = fits;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else
                begin
                    valid_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[j] <= fits ? (rem_in - trial) : rem_in;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
                tag_reg[j] <= tag_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[alts_pkg::Q_W-1];
    assign quo       = quo_reg[alts_pkg::Q_W-1];
    assign out_tag   = tag_reg[alts_pkg::Q_W-1];

endmodule
`default_nettype wire

@@ design/adc_level_to_s_units.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_level_to_s_units
// Converts an averaged 12-bit receiver level to S-units times 100 by
// piecewise-linear gain interpolation over ten fixed breakpoints.
// ----------------------------------------------------------------------------
//
//  channel   ports                        transfer
//  -------   --------------------------   ------------------------------------
//  input     start, busy, adc_level       edge with start high and busy low
//  result    done, s_hundredths,          edge ending the cycle done is high
//            at_full_scale
//
//  A new level can be taken every clock; busy is always low. Each result
//  passes through segment search, gain multiply, level multiply, 11 divider
//  stages (one quotient bit each) and the output register. The divider
//  stages set the latency.
//  Reset clears only the valid bits; no data is restored.
//  The receiver cannot stall, so the pipeline never holds.
//
//  Math per segment (r0, s0 lower breakpoint; r1, s1 upper):
//      value*100 = floor( x * (C + K*x) / (r0*r1*(r1-r0)) )
//  with K = 100*(s1*r0 - s0*r1) and C = 100*(s0*r1*(r1-r0)) - r0*K/100*100,
//  both folded into package constants. The numerator is never negative and
//  the quotient never exceeds 1500 inside a segment.
// ----------------------------------------------------------------------------
module adc_level_to_s_units (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [alts_pkg::X_W-1:0]   adc_level,
    output logic                            done,
    output logic [alts_pkg::Q_W-1:0]        s_hundredths,
    output logic                            at_full_scale
);

    // ---------------- stage 1: segment search ----------------
    logic [alts_pkg::CNT_W-1:0]  cnt_next;
    logic                        v1_reg;
    logic [alts_pkg::X_W-1:0]    x1_reg;
    logic [alts_pkg::CNT_W-1:0]  cnt1_reg;

    // Number of breakpoints strictly below the level; breakpoints rise,
    // so the highest one below gives the count.
    always_comb
    begin
        cnt_next = '0;
        for (int i = 0; i < alts_pkg::NUM_BRK; i++)
        begin
            if (adc_level > alts_pkg::BRK_LEVEL[i])
            begin
                cnt_next = alts_pkg::CNT_W'(i + 1);
            end
        end
    end

    // ---------------- stage 2: gain numerator ----------------
    alts_pkg::coef_t                   coef;
    logic [alts_pkg::SEG_W-1:0]        seg_idx;
    logic signed [alts_pkg::PROD_W-1:0] kx;
    logic signed [alts_pkg::SUM_W-1:0]  gain_sum;
    alts_pkg::tag_t                    tag2_next;

    logic                              v2_reg;
    logic [alts_pkg::X_W-1:0]          x2_reg;
    logic [alts_pkg::GAIN_W-1:0]       gain2_reg;
    logic [alts_pkg::DEN_W-1:0]        den2_reg;
    alts_pkg::tag_t                    tag2_reg;

    always_comb
    begin
        tag2_next.zero = (cnt1_reg == '0);
        tag2_next.full = (cnt1_reg == alts_pkg::CNT_W'(alts_pkg::NUM_BRK));
        // segment 0 spans the first and second breakpoints
        seg_idx  = (tag2_next.zero || tag2_next.full) ? '0
                                                       : (cnt1_reg - 1'b1);
        coef     = alts_pkg::seg_coef(seg_idx);
        kx       = coef.k * $signed({1'b0, x1_reg});
        gain_sum = alts_pkg::SUM_W'(kx) + alts_pkg::SUM_W'(coef.c);
    end

    // ---------------- stage 3: full numerator ----------------
    logic                              v3_reg;
    logic [alts_pkg::NUM_W-1:0]        num3_reg;
    logic [alts_pkg::DEN_W-1:0]        den3_reg;
    alts_pkg::tag_t                    tag3_reg;

    // ---------------- divider and output ----------------
    logic                              dv_valid;
    logic [alts_pkg::Q_W-1:0]          dv_quo;
    alts_pkg::tag_t                    dv_tag;

    logic                              done_reg;
    logic [alts_pkg::Q_W-1:0]          s_reg;
    logic                              full_reg;
    logic [alts_pkg::Q_W-1:0]          s_next;
    logic                              full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= adc_level;
        cnt1_reg  <= cnt_next;

        x2_reg    <= x1_reg;
        gain2_reg <= gain_sum[alts_pkg::GAIN_W-1:0];
        den2_reg  <= coef.den;
        tag2_reg  <= tag2_next;

        num3_reg  <= alts_pkg::NUM_W'(x2_reg) * alts_pkg::NUM_W'(gain2_reg);
        den3_reg  <= den2_reg;
        tag3_reg  <= tag2_reg;

        s_reg     <= s_next;
        full_reg  <= full_next;
    end

    alts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (num3_reg),
        .den       (den3_reg),
        .in_tag    (tag3_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_tag   (dv_tag)
    );

    // Final select: above the top breakpoint clamps, at or below the first
    // reads zero, otherwise the floored quotient with a safety clamp.
    always_comb
    begin
        if (dv_tag.full)
        begin
            s_next    = alts_pkg::FULL_SCALE;
            full_next = 1'b1;
        end
        else if (dv_tag.zero)
        begin
            s_next    = '0;
            full_next = 1'b0;
        end
        else if (dv_quo > alts_pkg::FULL_SCALE)
        begin
            s_next    = alts_pkg::FULL_SCALE;
            full_next = 1'b1;
        end
        else
        begin
            s_next    = dv_quo;
            full_next = 1'b0;
        end
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign s_hundredths  = s_reg;
    assign at_full_scale = full_reg;

endmodule
`default_nettype wire
